// File: rtl/core/assert_macros.svh
// Assertion macros used by the controller of the smoothing filter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define RESM_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define RESM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/resm_pkg.sv
// Shared constants and controller-to-datapath types for the smoothing filter.
`default_nettype none
package resm_pkg;
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int PIX_W      = 16;
    localparam int GFRAC_W    = 16;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int DIM_W      = 7;
    localparam int ACC_W      = 34;
    localparam int PROD_W     = 48;

    localparam logic [1:0] CFG_GAMMA  = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;
    localparam logic [1:0] CFG_PASSES = 2'd3;

    localparam logic [15:0]      GAMMA_RST  = 16'd32768;
    localparam logic [DIM_W-1:0] WIDTH_RST  = 7'd64;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 7'd64;
    localparam logic [1:0]       PASSES_RST = 2'd1;

    typedef struct packed {
        logic              wr_load;
        logic              wr_filt;
        logic [ADDR_W-1:0] wr_addr;
        logic [ADDR_W-1:0] rd_addr;
        logic              seed;
        logic              mul;
        logic              acc;
        logic              out_load;
        logic              out_last;
        logic              out_status;
    } t_dp_cmd;

    typedef struct packed {
        logic out_valid;
    } t_dp_stat;
endpackage
`default_nettype wire

// File: rtl/core/resm_dpath.sv
// Datapath: frame memory, multiply-accumulate recursion and output register.
`default_nettype none
module resm_dpath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire resm_pkg::t_dp_cmd                 i_cmd,
    input  wire logic [resm_pkg::GFRAC_W-1:0]      i_gamma,
    input  wire logic signed [resm_pkg::PIX_W-1:0] i_pixel_in,
    input  wire logic                              i_stall,
    output resm_pkg::t_dp_stat                     o_stat,
    output logic signed [resm_pkg::PIX_W-1:0]      o_pixel_out,
    output logic                                   o_last_pixel,
    output logic                                   o_status
);
    logic signed [resm_pkg::PIX_W-1:0]  r_mem [resm_pkg::DEPTH];
    logic signed [resm_pkg::PIX_W-1:0]  r_rdata;
    logic signed [resm_pkg::ACC_W-1:0]  r_acc;
    logic signed [resm_pkg::ACC_W-1:0]  r_p1;
    logic [resm_pkg::PROD_W-1:0]        r_p2;
    logic                               r_neg;
    logic                               r_out_valid;
    logic signed [resm_pkg::PIX_W-1:0]  r_pix_out;
    logic                               r_last;
    logic                               r_status;

    logic [resm_pkg::GFRAC_W:0]         omg;
    logic [resm_pkg::ACC_W-1:0]         acc_abs;
    logic [resm_pkg::PROD_W-1:0]        p2_up;
    logic [31:0]                        fb_mag;
    logic signed [resm_pkg::ACC_W-1:0]  fb;
    logic signed [resm_pkg::ACC_W-1:0]  acc_next;
    logic [17:0]                        q_mag;
    logic [17:0]                        q_neg;
    logic signed [resm_pkg::PIX_W-1:0]  wr_pix;

    always_comb begin
        omg      = 17'h10000 - {1'b0, i_gamma};
        acc_abs  = r_acc[resm_pkg::ACC_W-1] ? 34'(-r_acc) : 34'(r_acc);
        // Feedback is floor(g*acc/ONE); a negative acc rounds its magnitude up.
        p2_up    = r_p2 + 48'hFFFF;
        fb_mag   = r_neg ? p2_up[47:16] : r_p2[47:16];
        fb       = r_neg ? -$signed({2'b00, fb_mag}) : $signed({2'b00, fb_mag});
        acc_next = r_p1 + fb;
        // Stored pixel is acc/ONE truncated toward zero and saturated.
        q_mag    = acc_abs[33:16];
        q_neg    = ~q_mag + 18'd1;
        if (!r_acc[resm_pkg::ACC_W-1]) begin
            wr_pix = (q_mag > 18'd32767) ? 16'sh7FFF : $signed(q_mag[15:0]);
        end else begin
            wr_pix = (q_mag > 18'd32768) ? 16'sh8000 : $signed(q_neg[15:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_load) begin
            r_mem[i_cmd.wr_addr] <= i_pixel_in;
        end else if (i_cmd.wr_filt) begin
            r_mem[i_cmd.wr_addr] <= wr_pix;
        end
        r_rdata <= r_mem[i_cmd.rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.seed) begin
            r_acc <= $signed({{2{r_rdata[15]}}, r_rdata, 16'h0000});
        end else if (i_cmd.acc) begin
            r_acc <= acc_next;
        end
        if (i_cmd.mul) begin
            r_p1  <= $signed({1'b0, omg}) * r_rdata;
            r_p2  <= i_gamma * acc_abs[31:0];
            r_neg <= r_acc[resm_pkg::ACC_W-1];
        end
        if (i_cmd.out_load) begin
            r_pix_out <= i_cmd.out_status ? '0 : r_rdata;
            r_last    <= i_cmd.out_last;
            r_status  <= i_cmd.out_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.out_valid = r_out_valid;
    assign o_pixel_out      = r_pix_out;
    assign o_last_pixel     = r_last;
    assign o_status         = r_status;
endmodule
`default_nettype wire

// File: rtl/core/resm_ctrl.sv
// Controller: handshake, frame counters and the line-by-line filter sequencer.
`default_nettype none
`include "assert_macros.svh"
module resm_ctrl (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    input  wire logic                            i_op,
    input  wire logic                            i_stall,
    input  wire logic [resm_pkg::DIM_W-1:0]      i_width,
    input  wire logic [resm_pkg::DIM_W-1:0]      i_height,
    input  wire logic                            i_two_passes,
    input  wire logic [resm_pkg::CNT_W-1:0]      i_size,
    input  wire resm_pkg::t_dp_stat              i_stat,
    output logic                                 o_stall,
    output resm_pkg::t_dp_cmd                    o_cmd
);
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_RD_WAIT  = 3'd1;
    localparam logic [2:0] S_SEED_RD  = 3'd2;
    localparam logic [2:0] S_SEED_ACC = 3'd3;
    localparam logic [2:0] S_STEP_RD  = 3'd4;
    localparam logic [2:0] S_STEP_MUL = 3'd5;
    localparam logic [2:0] S_STEP_ACC = 3'd6;
    localparam logic [2:0] S_STEP_WR  = 3'd7;

    logic [2:0]                   r_state, n_state;
    logic [resm_pkg::CNT_W-1:0]   r_load_cnt, n_load_cnt;
    logic [resm_pkg::CNT_W-1:0]   r_read_cnt, n_read_cnt;
    logic                         r_ready, n_ready;
    logic                         r_last, n_last;
    logic                         r_status, n_status;
    logic                         r_phase, n_phase;
    logic [resm_pkg::DIM_W-1:0]   r_line, n_line;
    logic [resm_pkg::DIM_W-1:0]   r_idx, n_idx;
    logic                         r_pass, n_pass;
    logic                         r_dir, n_dir;
    logic [resm_pkg::ADDR_W-1:0]  r_addr, n_addr;
    logic [resm_pkg::ADDR_W-1:0]  r_base, n_base;
    logic [resm_pkg::ADDR_W-1:0]  r_end, n_end;

    logic                         accept;
    logic [resm_pkg::DIM_W-1:0]   len, nlines;
    logic [resm_pkg::ADDR_W-1:0]  stride, base_inc;
    logic                         idx_last, line_last, pass_last;
    logic [resm_pkg::CNT_W-1:0]   lc_base, lc_next, rc_next;
    logic                         frame_done;

    assign o_stall = (r_state != S_IDLE) || (i_op && i_stat.out_valid && i_stall);
    assign accept  = i_valid && !o_stall;

    always_comb begin
        len       = r_phase ? i_width : i_height;
        nlines    = r_phase ? i_height : i_width;
        stride    = r_phase ? resm_pkg::ADDR_W'(1) : resm_pkg::ADDR_W'(i_width);
        base_inc  = r_phase ? resm_pkg::ADDR_W'(i_width) : resm_pkg::ADDR_W'(1);
        idx_last  = (r_idx == len - 1'b1);
        line_last = (r_line == nlines - 1'b1);
        pass_last = r_pass || !i_two_passes;
        lc_base   = r_ready ? '0 : r_load_cnt;
        lc_next   = lc_base + 1'b1;
        rc_next   = r_read_cnt + 1'b1;
        frame_done = (r_state == S_STEP_WR) && idx_last && r_dir && pass_last
                     && line_last && r_phase;
    end

    always_comb begin
        n_state    = r_state;
        n_load_cnt = r_load_cnt;
        n_read_cnt = r_read_cnt;
        n_ready    = r_ready;
        n_last     = r_last;
        n_status   = r_status;
        n_phase    = r_phase;
        n_line     = r_line;
        n_idx      = r_idx;
        n_pass     = r_pass;
        n_dir      = r_dir;
        n_addr     = r_addr;
        n_base     = r_base;
        n_end      = r_end;
        unique case (r_state)
            S_IDLE: begin
                if (accept && !i_op) begin
                    if (lc_next >= i_size) begin
                        n_load_cnt = '0;
                        n_read_cnt = '0;
                        n_ready    = 1'b0;
                        n_phase    = 1'b0;
                        n_line     = '0;
                        n_idx      = '0;
                        n_pass     = 1'b0;
                        n_dir      = 1'b0;
                        n_addr     = '0;
                        n_base     = '0;
                        n_state    = S_SEED_RD;
                    end else begin
                        n_load_cnt = lc_next;
                        if (r_ready) begin
                            n_ready    = 1'b0;
                            n_read_cnt = '0;
                        end
                    end
                end else if (accept) begin
                    n_state = S_RD_WAIT;
                    if (!r_ready || r_read_cnt >= i_size) begin
                        n_status = 1'b1;
                        n_last   = 1'b0;
                        n_ready  = 1'b0;
                    end else begin
                        n_status = 1'b0;
                        n_last   = (rc_next == i_size);
                        if (rc_next >= i_size) begin
                            n_ready    = 1'b0;
                            n_read_cnt = '0;
                        end else begin
                            n_read_cnt = rc_next;
                        end
                    end
                end
            end
            S_RD_WAIT:  n_state = S_IDLE;
            S_SEED_RD:  n_state = S_SEED_ACC;
            S_SEED_ACC: n_state = S_STEP_RD;
            S_STEP_RD:  n_state = S_STEP_MUL;
            S_STEP_MUL: n_state = S_STEP_ACC;
            S_STEP_ACC: n_state = S_STEP_WR;
            S_STEP_WR: begin
                if (!idx_last) begin
                    n_idx   = r_idx + 1'b1;
                    n_addr  = r_dir ? r_addr - stride : r_addr + stride;
                    n_state = S_STEP_RD;
                end else begin
                    n_idx   = '0;
                    n_state = S_SEED_RD;
                    if (!r_dir) begin
                        n_end = r_addr;
                        if (!pass_last) begin
                            n_pass = 1'b1;
                            n_addr = r_base;
                        end else begin
                            n_pass = 1'b0;
                            n_dir  = 1'b1;
                        end
                    end else if (!pass_last) begin
                        n_pass = 1'b1;
                        n_addr = r_end;
                    end else begin
                        n_pass = 1'b0;
                        n_dir  = 1'b0;
                        if (!line_last) begin
                            n_line = r_line + 1'b1;
                            n_base = r_base + base_inc;
                            n_addr = r_base + base_inc;
                        end else if (!r_phase) begin
                            n_phase = 1'b1;
                            n_line  = '0;
                            n_base  = '0;
                            n_addr  = '0;
                        end else begin
                            n_state    = S_IDLE;
                            n_ready    = 1'b1;
                            n_read_cnt = '0;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_load_cnt <= '0;
            r_read_cnt <= '0;
            r_ready    <= 1'b0;
            r_last     <= 1'b0;
            r_status   <= 1'b0;
            r_phase    <= 1'b0;
            r_line     <= '0;
            r_idx      <= '0;
            r_pass     <= 1'b0;
            r_dir      <= 1'b0;
            r_addr     <= '0;
            r_base     <= '0;
            r_end      <= '0;
        end else begin
            r_state    <= n_state;
            r_load_cnt <= n_load_cnt;
            r_read_cnt <= n_read_cnt;
            r_ready    <= n_ready;
            r_last     <= n_last;
            r_status   <= n_status;
            r_phase    <= n_phase;
            r_line     <= n_line;
            r_idx      <= n_idx;
            r_pass     <= n_pass;
            r_dir      <= n_dir;
            r_addr     <= n_addr;
            r_base     <= n_base;
            r_end      <= n_end;
        end
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.wr_load    = (r_state == S_IDLE) && accept && !i_op;
        o_cmd.wr_filt    = (r_state == S_STEP_WR);
        o_cmd.wr_addr    = o_cmd.wr_filt ? r_addr : lc_base[resm_pkg::ADDR_W-1:0];
        o_cmd.rd_addr    = (r_state == S_IDLE) ? r_read_cnt[resm_pkg::ADDR_W-1:0] : r_addr;
        o_cmd.seed       = (r_state == S_SEED_ACC);
        o_cmd.mul        = (r_state == S_STEP_MUL);
        o_cmd.acc        = (r_state == S_STEP_ACC);
        o_cmd.out_load   = (r_state == S_RD_WAIT);
        o_cmd.out_last   = r_last;
        o_cmd.out_status = r_status;
    end

    `RESM_ASSERT(a_busy_stalls, i_clk, i_rst_n, r_state != S_IDLE, o_stall, "busy, no stall")
    `RESM_ASSERT(a_one_write, i_clk, i_rst_n, o_cmd.wr_filt, !o_cmd.wr_load, "two memory writes")
    `RESM_ASSERT_NEXT(a_done_ready, i_clk, i_rst_n, frame_done, r_ready && (r_state == S_IDLE), "frame end did not raise ready")
endmodule
`default_nettype wire

// File: rtl/core/recursive_exponential_smoothing_2d.sv
// Top level of the two-dimensional recursive exponential smoothing filter.
`default_nettype none
// A frame of signed 16-bit pixels is loaded in raster order with op 0, one
// beat per pixel. The beat that completes the frame starts the filter: every
// column and then every row gets a causal and an anti-causal first-order
// recursion (each repeated when cascade_passes is two or more), run in place
// on the frame memory by one multiply-accumulate unit. Every recursion step is
// a memory read, a multiply, an accumulate and a write back, and every pass
// starts with a seed read; the input side stalls while the filter runs. Read
// beats (op 1) return one result each, via the read-wait state and then a
// registered output that can wait for a stalled consumer; a load is accepted
// while a result waits there. A read with no frame ready returns status 1 and
// pixel 0. The user must write configuration registers only while the block
// is idle; the block itself does not enforce this.
module recursive_exponential_smoothing_2d (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic                              i_op,
    input  wire logic signed [resm_pkg::PIX_W-1:0] i_pixel_in,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic signed [resm_pkg::PIX_W-1:0]      o_pixel_out,
    output logic                                   o_last_pixel,
    output logic                                   o_status,
    input  wire logic                              i_cfg_we,
    input  wire logic [1:0]                        i_cfg_idx,
    input  wire logic [15:0]                       i_cfg_data
);
    logic [15:0]                   r_gamma;
    logic [resm_pkg::DIM_W-1:0]    r_width;
    logic [resm_pkg::DIM_W-1:0]    r_height;
    logic [1:0]                    r_passes;

    logic [resm_pkg::DIM_W-1:0]    eff_w, eff_h;
    logic [resm_pkg::CNT_W-1:0]    size;
    resm_pkg::t_dp_cmd             cmd;
    resm_pkg::t_dp_stat            stat;

    // Configuration registers; writes take effect at the clock edge.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma  <= resm_pkg::GAMMA_RST;
            r_width  <= resm_pkg::WIDTH_RST;
            r_height <= resm_pkg::HEIGHT_RST;
            r_passes <= resm_pkg::PASSES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                resm_pkg::CFG_GAMMA:  r_gamma  <= i_cfg_data;
                resm_pkg::CFG_WIDTH:  r_width  <= i_cfg_data[resm_pkg::DIM_W-1:0];
                resm_pkg::CFG_HEIGHT: r_height <= i_cfg_data[resm_pkg::DIM_W-1:0];
                resm_pkg::CFG_PASSES: r_passes <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Out-of-range sizes are clamped into one to the maximum dimension.
    always_comb begin
        if (r_width == '0) begin
            eff_w = resm_pkg::DIM_W'(1);
        end else if (r_width > resm_pkg::DIM_W'(resm_pkg::MAX_WIDTH)) begin
            eff_w = resm_pkg::DIM_W'(resm_pkg::MAX_WIDTH);
        end else begin
            eff_w = r_width;
        end
        if (r_height == '0) begin
            eff_h = resm_pkg::DIM_W'(1);
        end else if (r_height > resm_pkg::DIM_W'(resm_pkg::MAX_HEIGHT)) begin
            eff_h = resm_pkg::DIM_W'(resm_pkg::MAX_HEIGHT);
        end else begin
            eff_h = r_height;
        end
        size = resm_pkg::CNT_W'(eff_w) * resm_pkg::CNT_W'(eff_h);
    end

    resm_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_op         (i_op),
        .i_stall      (i_stall),
        .i_width      (eff_w),
        .i_height     (eff_h),
        .i_two_passes (r_passes >= 2'd2),
        .i_size       (size),
        .i_stat       (stat),
        .o_stall      (o_stall),
        .o_cmd        (cmd)
    );

    resm_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_gamma      (r_gamma),
        .i_pixel_in   (i_pixel_in),
        .i_stall      (i_stall),
        .o_stat       (stat),
        .o_pixel_out  (o_pixel_out),
        .o_last_pixel (o_last_pixel),
        .o_status     (o_status)
    );

    assign o_valid = stat.out_valid;
endmodule
`default_nettype wire

// File: verif/recursive_exponential_smoothing_2d_tb.sv
// Testbench for the 2D recursive exponential smoothing filter: directed and random frames.
`timescale 1ns / 1ps
module recursive_exponential_smoothing_2d_tb;
    localparam int  OP_LOAD = 0;
    localparam int  OP_READ = 1;
    localparam longint ONE_Q = 64'd1 << resm_pkg::GFRAC_W;
    localparam int  CYCLE_LIMIT = 3000000;

    // One filtered pixel as it is expected on the result side.
    typedef struct {
        logic signed [resm_pkg::PIX_W-1:0] pixel;
        logic                              last;
        logic                              status;
    } t_pixel_beat;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_valid;
    logic                              o_stall;
    logic                              i_op;
    logic signed [resm_pkg::PIX_W-1:0] i_pixel_in;
    logic                              o_valid;
    logic                              i_stall;
    logic signed [resm_pkg::PIX_W-1:0] o_pixel_out;
    logic                              o_last_pixel;
    logic                              o_status;
    logic                              i_cfg_we;
    logic [1:0]                        i_cfg_idx;
    logic [15:0]                       i_cfg_data;

    recursive_exponential_smoothing_2d u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_op         (i_op),
        .i_pixel_in   (i_pixel_in),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_pixel_out  (o_pixel_out),
        .o_last_pixel (o_last_pixel),
        .o_status     (o_status),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    // Mirror of the block's registers and frame memory.
    logic [15:0]                gamma_reg;
    logic [resm_pkg::DIM_W-1:0] width_reg;
    logic [resm_pkg::DIM_W-1:0] height_reg;
    logic [1:0]                 passes_reg;
    longint                     pixel_mem [resm_pkg::DEPTH];
    int unsigned                loaded_px;
    int unsigned                read_px;
    bit                         frame_ready;
    longint                     line_acc;

    t_pixel_beat      pending_pixels [$];
    int               error_count;
    int unsigned      cycle_count;
    int unsigned      beats_sent;
    bit               quiet;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // A run that hangs is stopped here rather than by the simulator.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int unsigned dim_eff(logic [resm_pkg::DIM_W-1:0] v, int unsigned max_v);
        if (v < 1) return 1;
        if (v > max_v) return max_v;
        return v;
    endfunction

    function automatic longint sat_pix(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // Feedback term floor(g * acc / ONE); negative values round toward minus infinity.
    function automatic longint feedback(longint g, longint a);
        if (a >= 0) return (g * a) >>> resm_pkg::GFRAC_W;
        return -(((g * (-a)) + (ONE_Q - 1)) >>> resm_pkg::GFRAC_W);
    endfunction

    function automatic longint acc_pixel(longint a);
        longint q;
        q = (a >= 0) ? a / ONE_Q : -((-a) / ONE_Q);
        return sat_pix(q);
    endfunction

    function automatic void smooth_step(int unsigned idx, longint g);
        line_acc = (ONE_Q - g) * pixel_mem[idx] + feedback(g, line_acc);
        pixel_mem[idx] = acc_pixel(line_acc);
    endfunction

    // Causal passes run forward from the first sample, then anti-causal passes backward.
    function automatic void smooth_line(int unsigned base, int unsigned stride,
                                        int unsigned n, int unsigned passes);
        longint g;
        g = gamma_reg;
        for (int p = 0; p < passes; p++) begin
            line_acc = pixel_mem[base] * ONE_Q;
            for (int i = 0; i < n; i++) smooth_step(base + i * stride, g);
        end
        for (int p = 0; p < passes; p++) begin
            line_acc = pixel_mem[base + (n - 1) * stride] * ONE_Q;
            for (int i = n; i > 0; i--) smooth_step(base + (i - 1) * stride, g);
        end
    endfunction

    function automatic void smooth_frame();
        int unsigned w, h, passes;
        w = dim_eff(width_reg, resm_pkg::MAX_WIDTH);
        h = dim_eff(height_reg, resm_pkg::MAX_HEIGHT);
        passes = (passes_reg >= 2) ? 2 : 1;
        for (int k = 0; k < w; k++) smooth_line(k, w, h, passes);
        for (int k = 0; k < h; k++) smooth_line(k * w, 1, w, passes);
    endfunction

    // Updates the mirror for one accepted beat and queues the pixel it returns, if any.
    function automatic void predict_beat(logic op, logic signed [resm_pkg::PIX_W-1:0] pix);
        int unsigned size;
        t_pixel_beat r;
        size = dim_eff(width_reg, resm_pkg::MAX_WIDTH) * dim_eff(height_reg, resm_pkg::MAX_HEIGHT);
        if (op == OP_LOAD) begin
            if (frame_ready) begin
                frame_ready = 0;
                read_px = 0;
                loaded_px = 0;
            end
            if (loaded_px < resm_pkg::DEPTH) pixel_mem[loaded_px] = sat_pix(pix);
            loaded_px++;
            if (loaded_px >= size) begin
                smooth_frame();
                loaded_px = 0;
                read_px = 0;
                frame_ready = 1;
            end
            return;
        end
        if (!frame_ready || read_px >= size) begin
            // Nothing to hand out: the block answers with status set.
            frame_ready = 0;
            r.pixel = '0;
            r.last = 1'b0;
            r.status = 1'b1;
        end else begin
            r.pixel = pixel_mem[read_px][resm_pkg::PIX_W-1:0];
            r.last = (read_px + 1 == size);
            r.status = 1'b0;
            read_px++;
            if (read_px >= size) begin
                frame_ready = 0;
                read_px = 0;
            end
        end
        pending_pixels.push_back(r);
    endfunction

    // Sends one beat; called right after a rising edge and returns right after the accepting one.
    task automatic send_beat(logic op, logic signed [resm_pkg::PIX_W-1:0] pix);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op;
        i_pixel_in <= pix;
        // Inputs only move at rising edges, so the falling edge sees the value the edge will.
        do @(negedge i_clk); while (o_stall);
        @(posedge i_clk);
        predict_beat(op, pix);
        beats_sent++;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        i_valid <= 1'b0;
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            resm_pkg::CFG_GAMMA:  gamma_reg = data;
            resm_pkg::CFG_WIDTH:  width_reg = data[resm_pkg::DIM_W-1:0];
            resm_pkg::CFG_HEIGHT: height_reg = data[resm_pkg::DIM_W-1:0];
            resm_pkg::CFG_PASSES: passes_reg = data[1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Upper data bits are junk the block must drop.
    task automatic set_frame(logic [15:0] gamma, logic [6:0] w, logic [6:0] h, logic [1:0] p);
        logic [15:0] junk;
        junk = $urandom;
        write_reg(resm_pkg::CFG_GAMMA, gamma);
        write_reg(resm_pkg::CFG_WIDTH, {junk[15:7], w});
        write_reg(resm_pkg::CFG_HEIGHT, {junk[8:0], h});
        write_reg(resm_pkg::CFG_PASSES, {junk[13:0], p});
    endtask

    // Brings the block to idle: a read beat cannot be taken while it filters, and reads go on
    // until no frame is pending, so a later size change never exposes stale memory.
    task automatic drain_frame();
        do send_beat(OP_READ, $urandom); while (frame_ready);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic load_frame(int unsigned n);
        for (int i = 0; i < n; i++) send_beat(OP_LOAD, $urandom);
    endtask

    // Consumer side: random stall bursts, none once the run turns quiet.
    int unsigned stall_left;
    always @(posedge i_clk) begin
        if (!i_rst_n || quiet) begin
            i_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_stall <= (stall_left != 1);
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(1, 10);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Result checker: a beat seen at the falling edge is taken at the next rising edge.
    always @(negedge i_clk) begin
        t_pixel_beat exp_px;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected result beat pixel=%0d last=%0b status=%0b",
                         $time, o_pixel_out, o_last_pixel, o_status);
                error_count++;
            end else begin
                exp_px = pending_pixels.pop_front();
                if (o_pixel_out !== exp_px.pixel) begin
                    $display("%0t: pixel_out expected %0d actual %0d",
                             $time, exp_px.pixel, o_pixel_out);
                    error_count++;
                end
                if (o_last_pixel !== exp_px.last) begin
                    $display("%0t: last_pixel expected %0b actual %0b",
                             $time, exp_px.last, o_last_pixel);
                    error_count++;
                end
                if (o_status !== exp_px.status) begin
                    $display("%0t: status expected %0b actual %0b",
                             $time, exp_px.status, o_status);
                    error_count++;
                end
            end
        end
    end

    // Reset defaults: a read with nothing loaded.
    task automatic test_idle_read();
        send_beat(OP_READ, 16'sh7fff);
        drain_frame();
    endtask

    // Extreme pixels, extreme gains, clamped sizes and pass counts.
    task automatic test_extremes();
        set_frame(16'd0, 7'd2, 7'd2, 2'd1);
        send_beat(OP_LOAD, 16'sh7fff);
        send_beat(OP_LOAD, -16'sh8000);
        send_beat(OP_LOAD, 16'sh0000);
        send_beat(OP_LOAD, -16'sh0001);
        drain_frame();
        // Passes three acts as two, width zero as one.
        set_frame(16'hffff, 7'd0, 7'd3, 2'd3);
        send_beat(OP_LOAD, -16'sh8000);
        send_beat(OP_LOAD, 16'sh7fff);
        send_beat(OP_LOAD, -16'sh8000);
        drain_frame();
        // Width above the maximum acts as the maximum; passes zero acts as one.
        set_frame(16'h8000, 7'd127, 7'd0, 2'd0);
        load_frame(resm_pkg::MAX_WIDTH);
        drain_frame();
    endtask

    // A load while results wait drops them; a size shrink in mid-frame fires the filter early.
    task automatic test_frame_control();
        set_frame(16'h4000, 7'd2, 7'd1, 2'd2);
        load_frame(2);
        send_beat(OP_READ, 0);
        send_beat(OP_LOAD, 16'sh1234);
        send_beat(OP_LOAD, -16'sh4321);
        drain_frame();
        set_frame(16'hc000, 7'd3, 7'd3, 2'd1);
        load_frame(5);
        drain_frame();
        write_reg(resm_pkg::CFG_HEIGHT, 16'd1);
        send_beat(OP_LOAD, 16'sh0100);
        drain_frame();
    endtask

    // Random configurations with mostly complete frames and some broken sequences.
    task automatic test_random_frames();
        int unsigned w, h, n, sel, cnt;
        logic [15:0] gamma;
        while (beats_sent < 540) begin
            sel = $urandom_range(0, 9);
            gamma = (sel == 0) ? 16'd0 : (sel == 1) ? 16'hffff : $urandom;
            if ($urandom_range(0, 9) == 0) begin
                w = $urandom_range(65, 127);
                h = $urandom_range(0, 1);
            end else begin
                w = $urandom_range(0, 8);
                h = $urandom_range(0, 8);
            end
            set_frame(gamma, w, h, $urandom_range(0, 3));
            n = dim_eff(w, resm_pkg::MAX_WIDTH) * dim_eff(h, resm_pkg::MAX_HEIGHT);
            sel = $urandom_range(0, 9);
            if (sel < 7) begin
                load_frame(n);
                cnt = n + $urandom_range(0, 2);
                for (int i = 0; i < cnt; i++) send_beat(OP_READ, $urandom);
            end else if (sel < 9) begin
                // Reads cut short by a new frame that then completes.
                load_frame(n);
                cnt = $urandom_range(0, n);
                for (int i = 0; i < cnt; i++) send_beat(OP_READ, $urandom);
                load_frame(n);
            end else begin
                for (int i = 0; i < n + 2; i++) send_beat($urandom_range(0, 1), $urandom);
            end
            drain_frame();
        end
    endtask

    // One full-width frame with both passes doubled, with no idling on either side.
    task automatic test_full_frame();
        quiet = 1;
        set_frame($urandom, 7'd64, 7'd2, 2'd2);
        load_frame(2 * resm_pkg::MAX_WIDTH);
        for (int i = 0; i <= 2 * resm_pkg::MAX_WIDTH; i++) send_beat(OP_READ, $urandom);
        drain_frame();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_op = 1'b0;
        i_pixel_in = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        cycle_count = 0;
        error_count = 0;
        beats_sent = 0;
        quiet = 0;
        gamma_reg = resm_pkg::GAMMA_RST;
        width_reg = resm_pkg::WIDTH_RST;
        height_reg = resm_pkg::HEIGHT_RST;
        passes_reg = resm_pkg::PASSES_RST;
        loaded_px = 0;
        read_px = 0;
        frame_ready = 0;
        line_acc = 0;
        foreach (pixel_mem[i]) pixel_mem[i] = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_read();
        test_extremes();
        test_frame_control();
        test_random_frames();
        test_full_frame();

        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && pending_pixels.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
